>>> rtl/opsp_pkg.sv
// Package for the octal SPI PSRAM slave: phase type, command codes,
// result kinds, mode register addresses, a command check and a latency helper function.
// No dependencies.
package opsp_pkg;

  // Transaction phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_ADDR = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // Input word kinds.
  localparam logic MODE_CS   = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  // Command words.
  localparam logic [15:0] CMD_REG_RD   = 16'h0040;
  localparam logic [15:0] CMD_REG_WR   = 16'h00C0;
  localparam logic [15:0] CMD_BURST_RD = 16'h0020;
  localparam logic [15:0] CMD_BURST_WR = 16'h00A0;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RANGE   = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  // Mode register addresses.
  localparam logic [31:0] MR0_ADDR = 32'd0;
  localparam logic [31:0] MR4_ADDR = 32'd4;

  // Byte counts of the command and address phases.
  localparam logic [2:0] CMD_BYTES  = 3'd2;
  localparam logic [2:0] ADDR_BYTES = 3'd4;

  // Reset latency settings.
  localparam logic [2:0] RD_LAT_CODE_RST  = 3'd2;
  localparam logic [2:0] WR_LAT_CODE_RST  = 3'd2;
  localparam logic [2:0] WR_LAT_CYC_RST   = 3'd5;
  localparam logic [4:0] REG_WR_LAT_EDGES = 5'd2;

  // True for the four supported commands.
  function automatic logic is_known(input logic [15:0] cmd);
    return cmd inside {CMD_REG_RD, CMD_REG_WR, CMD_BURST_RD, CMD_BURST_WR};
  endfunction

  // Map a write latency code to cycles; unmapped codes keep the old value.
  function automatic logic [2:0] wr_lat_cycles(input logic [2:0] code,
                                               input logic [2:0] old);
    logic [2:0] cyc;
    case (code)
      3'd0:    cyc = 3'd3;
      3'd4:    cyc = 3'd4;
      3'd2:    cyc = 3'd5;
      3'd6:    cyc = 3'd6;
      3'd1:    cyc = 3'd7;
      default: cyc = old;
    endcase
    return cyc;
  endfunction

endpackage

>>> rtl/opsp_if.sv
// Valid/ready channel interfaces for the octal SPI PSRAM slave: one for
// incoming bus words and one for result words. Depends on nothing.
interface opsp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] bus_byte;

  modport source (output valid, output mode, output bus_byte, input ready);
  modport sink   (input valid, input mode, input bus_byte, output ready);
endinterface

interface opsp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] read_byte;

  modport source (output valid, output kind, output read_byte, input ready);
  modport sink   (input valid, input kind, input read_byte, output ready);
endinterface

>>> rtl/octal_spi_psram_slave.sv
// Octal SPI PSRAM slave. A result word is registered and valid in the cycle after
// the bus word that causes it; the memory read port is registered as well.
// Throughput: one word per cycle, sustained, while the result side keeps up.
// Reset (synchronous, rst_n low): idle awaiting chip select, read and write latency
// codes RD_LAT_CODE_RST, WR_LAT_CODE_RST, write latency setting WR_LAT_CYC_RST.
// The memory is not cleared. Depends on opsp_pkg, opsp_if and opsp_ram.
module octal_spi_psram_slave #(
  parameter int MEM_BYTES = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  opsp_in_if.sink    in_chan,
  opsp_out_if.source out_chan
);

  localparam int AW = $clog2(MEM_BYTES);

  // Transaction state.
  opsp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [4:0]  lat_r, lat_nxt;
  logic        wr_acc_r, wr_acc_nxt;
  logic [2:0]  rd_code_r, rd_code_nxt;
  logic [2:0]  wr_code_r, wr_code_nxt;
  logic [2:0]  wr_cyc_r, wr_cyc_nxt;

  // Result stage.
  logic       res_valid_r;
  logic [1:0] res_kind_r;
  logic [7:0] res_byte_r;
  logic       res_mem_r;

  logic       accept;
  logic       in_ready;
  logic [15:0] cmd_shift;
  logic [2:0]  bytes_dec;
  logic        known;
  logic        data_edge;
  logic        in_range;
  logic [4:0]  lat_rd;
  logic [4:0]  lat_wr;
  logic [7:0]  byte_in;

  logic       res_new;
  logic [1:0] res_kind_new;
  logic [7:0] res_byte_new;
  logic       res_mem_new;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;

  // Handshake: a new word enters while the result stage is empty or draining.
  assign in_ready       = !res_valid_r || out_chan.ready;
  assign in_chan.ready  = in_ready;
  assign accept         = in_chan.valid && in_ready;
  assign byte_in        = in_chan.bus_byte;

  // Shared decode terms.
  assign cmd_shift = {byte_in, cmd_r[15:8]};
  assign bytes_dec = (bytes_left_r != 3'd0) ? bytes_left_r - 3'd1 : 3'd0;
  assign known     = opsp_pkg::is_known(cmd_r);
  assign data_edge = (phase_r == opsp_pkg::PH_DATA) && known && (lat_r == 5'd0);
  assign in_range  = addr_r < 32'(MEM_BYTES);
  assign lat_rd    = 5'({2'b00, rd_code_r} + 5'd3) << 1;
  assign lat_wr    = {1'b0, wr_cyc_r, 1'b0};

  // Next state of the transaction control and the latency settings.
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    lat_nxt        = lat_r;
    wr_acc_nxt     = wr_acc_r;
    rd_code_nxt    = rd_code_r;
    wr_code_nxt    = wr_code_r;
    wr_cyc_nxt     = wr_cyc_r;
    if (accept) begin
      if (in_chan.mode == opsp_pkg::MODE_CS) begin
        phase_nxt      = opsp_pkg::PH_CMD;
        bytes_left_nxt = opsp_pkg::CMD_BYTES;
      end else begin
        case (phase_r)
          opsp_pkg::PH_CMD: begin
            cmd_nxt        = cmd_shift;
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == 3'd0) begin
              phase_nxt      = opsp_pkg::PH_ADDR;
              bytes_left_nxt = opsp_pkg::ADDR_BYTES;
              if (cmd_shift == opsp_pkg::CMD_REG_RD ||
                  cmd_shift == opsp_pkg::CMD_BURST_RD) begin
                wr_acc_nxt = 1'b0;
                lat_nxt    = lat_rd;
              end else if (cmd_shift == opsp_pkg::CMD_REG_WR) begin
                wr_acc_nxt = 1'b1;
                lat_nxt    = opsp_pkg::REG_WR_LAT_EDGES;
              end else if (cmd_shift == opsp_pkg::CMD_BURST_WR) begin
                wr_acc_nxt = 1'b1;
                lat_nxt    = lat_wr;
              end else begin
                lat_nxt = 5'd0;
              end
            end
          end
          opsp_pkg::PH_ADDR: begin
            addr_nxt       = {addr_r[23:0], byte_in};
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == 3'd0) begin
              phase_nxt = opsp_pkg::PH_DATA;
            end
          end
          opsp_pkg::PH_DATA: begin
            if (known && lat_r != 5'd0) begin
              lat_nxt = lat_r - 5'd1;
            end else if (data_edge) begin
              if (cmd_r == opsp_pkg::CMD_REG_WR) begin
                if (addr_r == opsp_pkg::MR0_ADDR) begin
                  rd_code_nxt = byte_in[4:2];
                end else if (addr_r == opsp_pkg::MR4_ADDR) begin
                  wr_code_nxt = byte_in[7:5];
                  wr_cyc_nxt  = opsp_pkg::wr_lat_cycles(byte_in[7:5], wr_cyc_r);
                end
              end else if (cmd_r != opsp_pkg::CMD_REG_RD) begin
                addr_nxt = addr_r + 32'd1;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // Result words and memory accesses caused by the accepted word.
  always_comb begin
    res_new      = 1'b0;
    res_kind_new = opsp_pkg::KIND_BYTE;
    res_byte_new = 8'd0;
    res_mem_new  = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    if (accept && in_chan.mode == opsp_pkg::MODE_EDGE) begin
      if (phase_r == opsp_pkg::PH_CMD && bytes_dec == 3'd0 &&
          !opsp_pkg::is_known(cmd_shift)) begin
        res_new      = 1'b1;
        res_kind_new = opsp_pkg::KIND_UNKNOWN;
      end else if (data_edge) begin
        if (cmd_r == opsp_pkg::CMD_REG_RD) begin
          res_new = 1'b1;
          if (addr_r == opsp_pkg::MR0_ADDR) begin
            res_byte_new = {3'b000, rd_code_r, 2'b00};
          end else if (addr_r == opsp_pkg::MR4_ADDR) begin
            res_byte_new = {wr_code_r, 5'b00000};
          end
        end else if (cmd_r != opsp_pkg::CMD_REG_WR) begin
          if (!in_range) begin
            res_new      = 1'b1;
            res_kind_new = opsp_pkg::KIND_RANGE;
          end else if (wr_acc_r) begin
            ram_we = 1'b1;
          end else begin
            res_new     = 1'b1;
            res_mem_new = 1'b1;
            ram_re      = 1'b1;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= opsp_pkg::PH_IDLE;
      bytes_left_r <= 3'd0;
      cmd_r        <= 16'd0;
      addr_r       <= 32'd0;
      lat_r        <= 5'd0;
      wr_acc_r     <= 1'b0;
      rd_code_r    <= opsp_pkg::RD_LAT_CODE_RST;
      wr_code_r    <= opsp_pkg::WR_LAT_CODE_RST;
      wr_cyc_r     <= opsp_pkg::WR_LAT_CYC_RST;
      res_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      cmd_r        <= cmd_nxt;
      addr_r       <= addr_nxt;
      lat_r        <= lat_nxt;
      wr_acc_r     <= wr_acc_nxt;
      rd_code_r    <= rd_code_nxt;
      wr_code_r    <= wr_code_nxt;
      wr_cyc_r     <= wr_cyc_nxt;
      if (in_ready) begin
        res_valid_r <= res_new;
      end
    end
  end

  // Result payload; loaded whenever the stage can take a new word.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      res_kind_r <= res_kind_new;
      res_byte_r <= res_byte_new;
      res_mem_r  <= res_mem_new;
    end
  end

  // Memory array; read data arrives with the result stage and holds on stall.
  opsp_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (addr_r[AW-1:0]),
    .wdata(byte_in),
    .rdata(ram_rdata)
  );

  // Result channel.
  assign out_chan.valid     = res_valid_r;
  assign out_chan.kind      = res_kind_r;
  assign out_chan.read_byte = res_mem_r ? ram_rdata : res_byte_r;

endmodule

>>> rtl/opsp_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
module opsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
